// File: sv/nfa_pkg.sv
// Shared types, codes and constants of the NOR flash array model.
package nfa_pkg;

  localparam int unsigned FLASH_BYTES_DEF = 65536;
  localparam int unsigned READ_BURST_DEF = 64;
  localparam int unsigned OFF_W = 24;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned DIV_W = 17;
  localparam int unsigned REM_STEPS = OFF_W;
  localparam int unsigned CFG_W = 32;
  localparam logic [7:0] BYTE_ONES = 8'hff;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WREQ  = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_DATA  = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_ALIGN     = 3'd2,
    ST_NOT_ERASE = 3'd3,
    ST_BURST     = 3'd4
  } status_e_t;

  typedef enum logic [2:0] {
    CFG_PROGRAM_UNIT = 3'd0,
    CFG_ERASE_UNIT   = 3'd1,
    CFG_ERASED_VALUE = 3'd2,
    CFG_EXPLICIT     = 3'd3,
    CFG_DOUBLE       = 3'd4,
    CFG_WRITE_LIMIT  = 3'd5,
    CFG_ERASE_LIMIT  = 3'd6,
    CFG_CUT_LENGTH   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHK_ADDR,
    S_CHK_DATA,
    S_FIN,
    S_ERASE,
    S_RD_ADDR,
    S_RD_DATA,
    S_RMW,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [7:0]       data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
    logic [OFF_W-1:0] a;
    logic [OFF_W-1:0] b;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic a_zero;
    logic b_zero;
  } rem_rsp_t;

endpackage

// File: sv/nfa_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
interface nfa_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/nfa_mem.sv
// Byte-wide synchronous flash array storage, one write and one read port.
module nfa_mem #(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem_r [2**AW];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: sv/nfa_rem.sv
// Bit-serial remainder unit checking two dividends against one divisor.
module nfa_rem (
  input  logic            clk,
  input  logic            rst_n,
  input  nfa_pkg::rem_req_t req,
  output nfa_pkg::rem_rsp_t rsp
);
  import nfa_pkg::*;

  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [OFF_W-1:0] qa_r;
  logic [OFF_W-1:0] qb_r;
  logic [DIV_W-1:0] ra_r;
  logic [DIV_W-1:0] rb_r;
  logic [DIV_W-1:0] d_r;

  function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0] r,
                                                input logic b,
                                                input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[DIV_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(REM_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      qa_r <= req.a;
      qb_r <= req.b;
      ra_r <= '0;
      rb_r <= '0;
      d_r  <= req.divisor;
    end else if (busy_r) begin
      ra_r <= rem_step(ra_r, qa_r[OFF_W-1], d_r);
      rb_r <= rem_step(rb_r, qb_r[OFF_W-1], d_r);
      qa_r <= {qa_r[OFF_W-2:0], 1'b0};
      qb_r <= {qb_r[OFF_W-2:0], 1'b0};
    end
  end

  assign rsp.done   = done_r;
  assign rsp.a_zero = (ra_r == '0);
  assign rsp.b_zero = (rb_r == '0);
endmodule

// File: sv/nor_flash_array_model.sv
// NOR flash array model: control sequencer, configuration and result register.
// After reset the block sweeps the array to 0xFF, one byte per cycle, and
// accepts no beat until the sweep ends. A write data beat makes one read and
// one write of the array port. A read passes every byte through the single
// read port and the result register. Write and erase requests first pass
// through the bit-serial remainder unit for the alignment check; a write
// request with the erased-target check then scans each byte in S_CHK_ADDR and
// S_CHK_DATA, and an erase fills one byte per cycle. Errors, acknowledgements
// and empty reads return through S_RESP.
module nor_flash_array_model #(
  parameter int unsigned FLASH_BYTES = nfa_pkg::FLASH_BYTES_DEF,
  parameter int unsigned READ_BURST  = nfa_pkg::READ_BURST_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  nfa_stream_if.sink                 in_ch,
  nfa_stream_if.source               out_ch,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [nfa_pkg::CFG_W-1:0]  cfg_wdata
);
  import nfa_pkg::*;

  localparam int unsigned AW = $clog2(FLASH_BYTES);
  localparam logic [OFF_W:0] FB_W = (OFF_W + 1)'(FLASH_BYTES);
  localparam logic [LEN_W-1:0] BURST_W = LEN_W'(READ_BURST);

  state_t state_r, state_nxt;

  logic [6:0]       pu_r;
  logic [DIV_W-1:0] eu_r;
  logic [7:0]       ev_r;
  logic             explicit_r;
  logic             double_r;
  logic [CNT_W-1:0] wlim_r;
  logic [CNT_W-1:0] elim_r;
  logic [LEN_W-1:0] cut_r;

  logic [CNT_W-1:0] wc_r;
  logic [CNT_W-1:0] ec_r;
  logic [OFF_W-1:0] wp_r;
  logic [LEN_W-1:0] exp_r;
  logic [LEN_W-1:0] store_r;

  logic [1:0]       cmd_r;
  logic [OFF_W-1:0] off_r;
  logic [LEN_W-1:0] len_r;
  logic [7:0]       dat_r;
  logic [2:0]       status_r;
  logic [AW-1:0]    ptr_r;
  logic [LEN_W-1:0] cnt_r;
  logic [AW-1:0]    clr_r;

  logic      out_v_r;
  out_item_t out_d_r;

  logic      in_acc;
  logic      out_free;
  in_item_t  item;
  logic      rng_ok;
  logic      wp_ok;
  logic [2:0] acc_status;
  logic      emit;
  out_item_t emit_d;
  logic      mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic [7:0]    prog_byte;
  logic [CNT_W-1:0] ec_inc;
  logic [LEN_W-1:0] keep;
  rem_req_t  rem_req;
  rem_rsp_t  rem_rsp;

  assign item     = in_ch.data;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  assign rng_ok = ({1'b0, item.offset} < FB_W) &&
                  ((FB_W - {1'b0, item.offset}) >= (OFF_W + 1)'(item.length));
  assign wp_ok  = ({1'b0, wp_r} < FB_W);
  assign ec_inc = ec_r + CNT_W'(1);

  assign prog_byte = !explicit_r ? dat_r :
                     (ev_r == BYTE_ONES) ? (dat_r & mem_rdata) : (dat_r | mem_rdata);

  always_comb begin
    keep = len_r;
    if (wlim_r != '0) begin
      if (wc_r > wlim_r) begin
        keep = '0;
      end else if (wc_r == wlim_r) begin
        keep = (cut_r < len_r) ? cut_r : len_r;
      end
    end
  end

  always_comb begin
    acc_status = ST_OK;
    case (item.command)
      CMD_READ: begin
        if (!rng_ok) begin
          acc_status = ST_RANGE;
        end else if (item.length > BURST_W) begin
          acc_status = ST_BURST;
        end
      end
      CMD_WREQ: begin
        if (!rng_ok) begin
          acc_status = ST_RANGE;
        end else if (pu_r == '0) begin
          acc_status = ST_ALIGN;
        end
      end
      CMD_ERASE: begin
        if (!rng_ok) begin
          acc_status = ST_RANGE;
        end else if (eu_r == '0) begin
          acc_status = ST_ALIGN;
        end
      end
      default: acc_status = ST_OK;
    endcase
  end

  assign rem_req.start   = in_acc && (acc_status == ST_OK) &&
                           ((item.command == CMD_WREQ) || (item.command == CMD_ERASE));
  assign rem_req.divisor = (item.command == CMD_WREQ) ? DIV_W'(pu_r) : eu_r;
  assign rem_req.a       = item.offset;
  assign rem_req.b       = OFF_W'(item.length);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RESP;
          case (item.command)
            CMD_READ: begin
              if (acc_status == ST_OK && item.length != '0) state_nxt = S_RD_ADDR;
            end
            CMD_WREQ, CMD_ERASE: begin
              if (acc_status == ST_OK) state_nxt = S_DIV;
            end
            default: begin
              if (exp_r != '0 && store_r != '0 && wp_ok) state_nxt = S_RMW;
            end
          endcase
        end
      end
      S_DIV: begin
        if (rem_rsp.done) begin
          if (!(rem_rsp.a_zero && rem_rsp.b_zero)) begin
            state_nxt = S_RESP;
          end else if (cmd_r == CMD_WREQ) begin
            state_nxt = (explicit_r && !double_r && len_r != '0) ? S_CHK_ADDR : S_FIN;
          end else if ((elim_r != '0 && ec_inc >= elim_r) || len_r == '0) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_ERASE;
          end
        end
      end
      S_CHK_ADDR: state_nxt = S_CHK_DATA;
      S_CHK_DATA: begin
        if (mem_rdata != ev_r) begin
          state_nxt = S_RESP;
        end else if (cnt_r == LEN_W'(1)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK_ADDR;
        end
      end
      S_FIN: state_nxt = S_RESP;
      S_ERASE: begin
        if (cnt_r == LEN_W'(1)) state_nxt = S_RESP;
      end
      S_RD_ADDR: state_nxt = S_RD_DATA;
      S_RD_DATA: begin
        if (out_free) state_nxt = (cnt_r == LEN_W'(1)) ? S_IDLE : S_RD_ADDR;
      end
      S_RMW: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_d    = '{status: ST_OK, read_byte: 8'd0, last: 1'b1};
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = ev_r;
    mem_raddr = ptr_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = BYTE_ONES;
      end
      S_IDLE: mem_raddr = wp_r[AW-1:0];
      S_ERASE: mem_we = 1'b1;
      S_RD_DATA: begin
        emit   = out_free;
        emit_d = '{status: ST_OK, read_byte: mem_rdata, last: (cnt_r == LEN_W'(1))};
      end
      S_RMW: begin
        mem_raddr = wp_r[AW-1:0];
        mem_waddr = wp_r[AW-1:0];
        mem_wdata = prog_byte;
        mem_we    = out_free;
        emit      = out_free;
      end
      S_RESP: begin
        emit   = out_free;
        emit_d = '{status: status_r, read_byte: 8'd0, last: 1'b1};
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      out_v_r    <= 1'b0;
      pu_r       <= 7'd4;
      eu_r       <= DIV_W'(4096);
      ev_r       <= BYTE_ONES;
      explicit_r <= 1'b1;
      double_r   <= 1'b0;
      wlim_r     <= '0;
      elim_r     <= '0;
      cut_r      <= '0;
      wc_r       <= '0;
      ec_r       <= '0;
      wp_r       <= '0;
      exp_r      <= '0;
      store_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROGRAM_UNIT: pu_r       <= cfg_wdata[6:0];
          CFG_ERASE_UNIT:   eu_r       <= cfg_wdata[DIV_W-1:0];
          CFG_ERASED_VALUE: ev_r       <= cfg_wdata[7:0];
          CFG_EXPLICIT:     explicit_r <= cfg_wdata[0];
          CFG_DOUBLE:       double_r   <= cfg_wdata[0];
          CFG_WRITE_LIMIT:  wlim_r     <= cfg_wdata;
          CFG_ERASE_LIMIT:  elim_r     <= cfg_wdata;
          CFG_CUT_LENGTH:   cut_r      <= cfg_wdata[LEN_W-1:0];
          default:          cut_r      <= cut_r;
        endcase
      end
      if (in_acc && item.command == CMD_WREQ) begin
        exp_r   <= '0;
        store_r <= '0;
      end
      if (in_acc && item.command == CMD_DATA && exp_r != '0 &&
          !(store_r != '0 && wp_ok)) begin
        wp_r  <= wp_r + OFF_W'(1);
        exp_r <= exp_r - LEN_W'(1);
      end
      if (state_r == S_DIV && rem_rsp.done && rem_rsp.a_zero && rem_rsp.b_zero) begin
        if (cmd_r == CMD_WREQ) begin
          wc_r <= wc_r + CNT_W'(1);
        end else begin
          ec_r <= ec_inc;
        end
      end
      if (state_r == S_FIN) begin
        wp_r    <= off_r;
        exp_r   <= len_r;
        store_r <= keep;
      end
      if (state_r == S_RMW && out_free) begin
        wp_r    <= wp_r + OFF_W'(1);
        exp_r   <= exp_r - LEN_W'(1);
        store_r <= store_r - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_d_r <= emit_d;
    if (in_acc) begin
      cmd_r    <= item.command;
      off_r    <= item.offset;
      len_r    <= item.length;
      dat_r    <= item.data_byte;
      status_r <= acc_status;
      ptr_r    <= item.offset[AW-1:0];
      cnt_r    <= item.length;
    end
    if (state_r == S_DIV && rem_rsp.done && !(rem_rsp.a_zero && rem_rsp.b_zero)) begin
      status_r <= ST_ALIGN;
    end
    if (state_r == S_CHK_DATA) begin
      if (mem_rdata != ev_r) begin
        status_r <= ST_NOT_ERASE;
      end else begin
        ptr_r <= ptr_r + AW'(1);
        cnt_r <= cnt_r - LEN_W'(1);
      end
    end
    if (state_r == S_ERASE || (state_r == S_RD_DATA && out_free)) begin
      ptr_r <= ptr_r + AW'(1);
      cnt_r <= cnt_r - LEN_W'(1);
    end
  end

  nfa_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  nfa_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );
endmodule
